FILE: src/plcs_pkg.sv
`timescale 1ns / 1ps

package plcs_pkg;

    localparam int NumClasses = 4;

    localparam logic [31:0] ALL_ONES_32 = 32'hFFFF_FFFF;
    localparam logic [63:0] ALL_ONES_64 = 64'hFFFF_FFFF_FFFF_FFFF;

    // Operation codes carried by the opcode field.
    localparam logic [1:0] OP_RECORD       = 2'd0;
    localparam logic [1:0] OP_REPORT       = 2'd1;
    localparam logic [1:0] OP_CLEAR        = 2'd2;
    localparam logic [1:0] OP_REPORT_CLEAR = 2'd3;

    // Upstream packet kinds.
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;

    // Class indexes, in report order.
    localparam logic [1:0] CLS_UP_DATA   = 2'd0;
    localparam logic [1:0] CLS_UP_OPEN   = 2'd1;
    localparam logic [1:0] CLS_UP_CLOSE  = 2'd2;
    localparam logic [1:0] CLS_DOWN_DATA = 2'd3;

    typedef logic [1:0] class_idx_t;

    // Downstream packets are always data; upstream kinds other than data and
    // close fall into the open-or-other class.
    function automatic class_idx_t pick_class(input logic up, input logic [1:0] kind);
        class_idx_t c;
        if (!up) begin
            c = CLS_DOWN_DATA;
        end else if (kind == KIND_DATA) begin
            c = CLS_UP_DATA;
        end else if (kind == KIND_CLOSE) begin
            c = CLS_UP_CLOSE;
        end else begin
            c = CLS_UP_OPEN;
        end
        return c;
    endfunction

endpackage

FILE: src/packet_latency_class_statistics.sv
`timescale 1ns / 1ps

// Per-class packet latency statistics. Four classes (upstream data, upstream
// open or other, upstream close, downstream data) each keep a saturating
// sample count, a saturating 64-bit sum, a minimum and a maximum. A word is
// taken when start is high and busy is low. A record word takes effect at
// that edge and never raises busy, so records can arrive every cycle while
// no report holds busy high. A clear word likewise leaves busy low. A report
// word raises busy and emits four result words in class order, each shown
// for exactly one cycle with result_valid high; the receiver cannot stall
// them and must take each one as it appears. The last word of a report
// carries last_of_report. The mean of each class comes from one shared
// restoring divider that produces one quotient bit per cycle; each class
// passes through a setup state, then 32 divide steps, then an emit state,
// and the divide steps are skipped when a class is empty or its quotient
// saturates. For a report-then-clear word the classes are cleared right
// after the fourth result word.
module packet_latency_class_statistics
    import plcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [31:0] time_us,
    input  logic        is_upstream,
    input  logic [1:0]  packet_kind,
    output logic        result_valid,
    output logic [1:0]  class_index,
    output logic [31:0] sample_count,
    output logic [31:0] min_time,
    output logic [31:0] max_time,
    output logic [31:0] mean_time,
    output logic        last_of_report
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]  state_reg, state_next;
    class_idx_t  cls_reg, cls_next;
    logic        op3_reg, op3_next;
    logic [4:0]  step_reg, step_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic        valid_reg, valid_next;

    logic [31:0] count_reg [NumClasses];
    logic [63:0] sum_reg   [NumClasses];
    logic [31:0] min_reg   [NumClasses];
    logic [31:0] max_reg   [NumClasses];
    logic [31:0] count_next [NumClasses];
    logic [63:0] sum_next   [NumClasses];
    logic [31:0] min_next   [NumClasses];
    logic [31:0] max_next   [NumClasses];

    logic [1:0]  index_reg, index_next;
    logic [31:0] out_count_reg, out_count_next;
    logic [31:0] out_min_reg, out_min_next;
    logic [31:0] out_max_reg, out_max_next;
    logic [31:0] out_mean_reg, out_mean_next;
    logic        out_last_reg, out_last_next;

    logic        accept;
    class_idx_t  idx;
    logic [31:0] cur_count;
    logic [63:0] cur_sum;
    logic [31:0] cur_min;
    logic [31:0] cur_max;
    logic [64:0] sum_ext;
    logic [32:0] rem_shift;
    logic [32:0] trial;
    logic        do_emit;
    logic [31:0] emit_mean;

    assign accept = start && !busy;

    // One class is selected for reading and recording: the record class while
    // idle, the class under report otherwise.
    assign idx       = (state_reg == ST_IDLE) ? pick_class(is_upstream, packet_kind) : cls_reg;
    assign cur_count = count_reg[idx];
    assign cur_sum   = sum_reg[idx];
    assign cur_min   = min_reg[idx];
    assign cur_max   = max_reg[idx];
    assign sum_ext   = {1'b0, cur_sum} + {33'd0, time_us};

    // One restoring divide step: the remainder stays below the count, so a
    // 33-bit trial subtraction decides each quotient bit.
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign trial     = rem_shift - {1'b0, cur_count};

    always_comb
    begin
        state_next     = state_reg;
        cls_next       = cls_reg;
        op3_next       = op3_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        valid_next     = 1'b0;
        count_next     = count_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        index_next     = index_reg;
        out_count_next = out_count_reg;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        out_mean_next  = out_mean_reg;
        out_last_next  = out_last_reg;
        do_emit        = 1'b0;
        emit_mean      = 32'd0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    case (opcode)
                        OP_RECORD:
                        begin
                            if (cur_count != ALL_ONES_32) begin
                                count_next[idx] = cur_count + 32'd1;
                            end
                            sum_next[idx] = sum_ext[64] ? ALL_ONES_64 : sum_ext[63:0];
                            if (time_us > cur_max) begin
                                max_next[idx] = time_us;
                            end
                            if (time_us < cur_min) begin
                                min_next[idx] = time_us;
                            end
                        end
                        OP_CLEAR:
                        begin
                            for (int c = 0; c < NumClasses; c++) begin
                                count_next[c] = 32'd0;
                                sum_next[c]   = 64'd0;
                                min_next[c]   = ALL_ONES_32;
                                max_next[c]   = 32'd0;
                            end
                        end
                        default:
                        begin
                            cls_next   = CLS_UP_DATA;
                            op3_next   = (opcode == OP_REPORT_CLEAR);
                            state_next = ST_SETUP;
                        end
                    endcase
                end
            end
            ST_SETUP:
            begin
                // An empty class has mean zero; a high sum half at or above
                // the count means the quotient does not fit in 32 bits.
                if (cur_count == 32'd0) begin
                    do_emit   = 1'b1;
                    emit_mean = 32'd0;
                end else if (cur_sum[63:32] >= cur_count) begin
                    do_emit   = 1'b1;
                    emit_mean = ALL_ONES_32;
                end else begin
                    rem_next   = cur_sum[63:32];
                    quo_next   = cur_sum[31:0];
                    step_next  = 5'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!trial[32]) begin
                    rem_next = trial[31:0];
                end else begin
                    rem_next = rem_shift[31:0];
                end
                quo_next  = {quo_reg[30:0], ~trial[32]};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd31) begin
                    do_emit   = 1'b1;
                    emit_mean = quo_next;
                end
            end
            ST_EMIT:
            begin
                if (cls_reg == CLS_DOWN_DATA) begin
                    if (op3_reg) begin
                        for (int c = 0; c < NumClasses; c++) begin
                            count_next[c] = 32'd0;
                            sum_next[c]   = 64'd0;
                            min_next[c]   = ALL_ONES_32;
                            max_next[c]   = 32'd0;
                        end
                    end
                    state_next = ST_IDLE;
                end else begin
                    cls_next   = cls_reg + 2'd1;
                    state_next = ST_SETUP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (do_emit) begin
            index_next     = cls_reg;
            out_count_next = cur_count;
            out_min_next   = cur_min;
            out_max_next   = cur_max;
            out_mean_next  = emit_mean;
            out_last_next  = (cls_reg == CLS_DOWN_DATA);
            valid_next     = 1'b1;
            state_next     = ST_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            cls_reg   <= CLS_UP_DATA;
            op3_reg   <= 1'b0;
            valid_reg <= 1'b0;
            for (int c = 0; c < NumClasses; c++) begin
                count_reg[c] <= 32'd0;
                sum_reg[c]   <= 64'd0;
                min_reg[c]   <= ALL_ONES_32;
                max_reg[c]   <= 32'd0;
            end
        end else begin
            state_reg <= state_next;
            cls_reg   <= cls_next;
            op3_reg   <= op3_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
        end
    end

    // Divider and result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        step_reg      <= step_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        index_reg     <= index_next;
        out_count_reg <= out_count_next;
        out_min_reg   <= out_min_next;
        out_max_reg   <= out_max_next;
        out_mean_reg  <= out_mean_next;
        out_last_reg  <= out_last_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign result_valid   = valid_reg;
    assign class_index    = index_reg;
    assign sample_count   = out_count_reg;
    assign min_time       = out_min_reg;
    assign max_time       = out_max_reg;
    assign mean_time      = out_mean_reg;
    assign last_of_report = out_last_reg;

    // A result word only appears while a report is in progress.
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result word outside a report");

    // The final word of a report belongs to the downstream data class.
    a_last_class: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_report |-> class_index == CLS_DOWN_DATA)
        else $error("last_of_report on wrong class");

    // An empty class always reports a zero mean.
    a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && sample_count == 32'd0 |-> mean_time == 32'd0)
        else $error("nonzero mean for empty class");

    // A record word never produces a result word in the next cycle.
    a_record_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == OP_RECORD |=> !result_valid && !busy)
        else $error("record word started a report");

endmodule
